// ===== src/assert_macros.svh =====
// Assertion helpers used by the instruction execute RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define CPU8_ASSERT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cpu8 assertion failed");

// Implication whose consequent is checked in the next cycle.
`define CPU8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cpu8 next-cycle assertion failed");

`endif

// ===== src/cpu8x_pkg.sv =====
package cpu8x_pkg;

	// Operation codes of the decoded instruction word.
	typedef enum logic [5:0] {
		OP_ILL = 6'd0,  OP_ADC = 6'd1,  OP_AND = 6'd2,  OP_ASL = 6'd3,
		OP_BCC = 6'd4,  OP_BCS = 6'd5,  OP_BEQ = 6'd6,  OP_BIT = 6'd7,
		OP_BMI = 6'd8,  OP_BNE = 6'd9,  OP_BPL = 6'd10, OP_BRK = 6'd11,
		OP_BVC = 6'd12, OP_BVS = 6'd13, OP_CLC = 6'd14, OP_CLD = 6'd15,
		OP_CLI = 6'd16, OP_CLV = 6'd17, OP_CMP = 6'd18, OP_CPX = 6'd19,
		OP_CPY = 6'd20, OP_DEC = 6'd21, OP_DEX = 6'd22, OP_DEY = 6'd23,
		OP_EOR = 6'd24, OP_INC = 6'd25, OP_INX = 6'd26, OP_INY = 6'd27,
		OP_JMP = 6'd28, OP_JSR = 6'd29, OP_LDA = 6'd30, OP_LDX = 6'd31,
		OP_LDY = 6'd32, OP_LSR = 6'd33, OP_NOP = 6'd34, OP_ORA = 6'd35,
		OP_PHA = 6'd36, OP_PHP = 6'd37, OP_PLA = 6'd38, OP_PLP = 6'd39,
		OP_ROL = 6'd40, OP_ROR = 6'd41, OP_RTI = 6'd42, OP_RTS = 6'd43,
		OP_SBC = 6'd44, OP_SEC = 6'd45, OP_SED = 6'd46, OP_SEI = 6'd47,
		OP_STA = 6'd48, OP_STX = 6'd49, OP_STY = 6'd50, OP_TAX = 6'd51,
		OP_TAY = 6'd52, OP_TSX = 6'd53, OP_TXA = 6'd54, OP_TXS = 6'd55,
		OP_TYA = 6'd56
	} op_t;

	// Status bit positions.
	localparam int unsigned FLAG_C = 0;
	localparam int unsigned FLAG_Z = 1;
	localparam int unsigned FLAG_I = 2;
	localparam int unsigned FLAG_D = 3;
	localparam int unsigned FLAG_B = 4;
	localparam int unsigned FLAG_U = 5;
	localparam int unsigned FLAG_V = 6;
	localparam int unsigned FLAG_N = 7;

	localparam logic [7:0] SP_RESET = 8'hFD;
	localparam logic [7:0] P_RESET  = 8'h24;
	localparam logic [7:0] PUSH_BU  = 8'h30;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUSH,
		ST_PULL
	} state_t;

	// One result word.
	typedef struct packed {
		logic        wv;
		logic [15:0] wa;
		logic [7:0]  wd;
		logic [15:0] pc;
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  p;
		logic [7:0]  sp;
		logic [2:0]  cost;
	} res_t;

endpackage

// ===== src/cpu8x_instr_if.sv =====
interface cpu8x_instr_if;
	logic        valid;
	logic        ready;
	logic [5:0]  operation;
	logic [7:0]  operand_value;
	logic [15:0] target_address;
	logic        accumulator_mode;
	logic [15:0] fetch_pc;

	modport source (output valid, operation, operand_value, target_address,
		accumulator_mode, fetch_pc, input ready);
	modport sink (input valid, operation, operand_value, target_address,
		accumulator_mode, fetch_pc, output ready);
endinterface

// ===== src/cpu8x_result_if.sv =====
interface cpu8x_result_if;
	logic        valid;
	logic        ready;
	logic        write_valid;
	logic [15:0] write_address;
	logic [7:0]  write_data;
	logic [15:0] next_pc;
	logic [7:0]  acc_out;
	logic [7:0]  x_out;
	logic [7:0]  y_out;
	logic [7:0]  status_out;
	logic [7:0]  sp_out;
	logic [2:0]  cost;

	modport source (output valid, write_valid, write_address, write_data, next_pc,
		acc_out, x_out, y_out, status_out, sp_out, cost, input ready);
	modport sink (input valid, write_valid, write_address, write_data, next_pc,
		acc_out, x_out, y_out, status_out, sp_out, cost, output ready);
endinterface

// ===== src/cpu8x_ram.sv =====
module cpu8x_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== src/cpu8_instruction_execute.sv =====
// Channel   Dir  Payload
// instr     in   operation, operand_value, target_address, accumulator_mode, fetch_pc
// result    out  write_valid/address/data, next_pc, registers, cost
// cfg       in   break_vector_we, break_vector_wdata (break vector)
// A new word may enter every cycle while the sequencer is idle and the output slot is free.
// PHA/PHP push one byte, JSR two and BRK three: one stack write per cycle on the RAM port.
// PLA/PLP pull one byte, RTS two and RTI three: one stack read per cycle, read port registered.
// After reset all 256 stack RAM entries are cleared before the first word is taken.
// A result waiting in the output register stalls input until the result channel is ready.
`include "assert_macros.svh"

module cpu8_instruction_execute (
	input  logic                   clk,
	input  logic                   arst_n,
	cpu8x_instr_if.sink            instr,
	cpu8x_result_if.source         result,
	input  logic                   break_vector_we,
	input  logic [15:0]            break_vector_wdata
);
	cpu8x_pkg::state_t state_q, state_d;

	logic [7:0]  a_q, x_q, y_q, sp_q, p_q;
	logic [15:0] bv_q;
	logic [7:0]  clr_q;

	// Push sequencing.
	logic [7:0]  wa_q;
	logic [1:0]  push_n_q;
	logic [7:0]  push_b0_q, push_b1_q;

	// Pull sequencing.
	cpu8x_pkg::op_t pop_op_q;
	logic [1:0]  pop_n_q, pop_i_q;
	logic [7:0]  ra_q, byte0_q, byte1_q;
	logic [15:0] pop_pc_q;

	cpu8x_pkg::res_t res_q;
	logic            res_v_q;

	logic            fire, slot_free, load_res;
	cpu8x_pkg::op_t  op;
	cpu8x_pkg::res_t ex, pl;
	logic [1:0]      ex_push_n, ex_pull_n;
	logic [7:0]      ex_pb0, ex_pb1, ex_pb2;
	logic            pull_done;

	logic        ram_we;
	logic [7:0]  ram_wa, ram_wd, ram_ra, ram_rd;

	function automatic logic [7:0] set_zn(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] r;
		r = p;
		r[cpu8x_pkg::FLAG_Z] = (v == 8'h00);
		r[cpu8x_pkg::FLAG_N] = v[7];
		return r;
	endfunction

	assign op        = cpu8x_pkg::op_t'(instr.operation);
	assign slot_free = !res_v_q || result.ready;
	assign instr.ready = (state_q == cpu8x_pkg::ST_IDLE) && slot_free;
	assign fire      = instr.valid && instr.ready;
	assign pull_done = (state_q == cpu8x_pkg::ST_PULL) && (pop_i_q == pop_n_q - 2'd1);

	// Combinational execution of the incoming word.
	always_comb begin
		logic [8:0]  bin;
		logic [4:0]  lo, hi;
		logic [5:0]  slo, shi;
		logic [7:0]  r, dres, v, a;
		logic [15:0] pc, np, pc1;
		logic        c, take, isbr;
		v    = instr.operand_value;
		a    = a_q;
		pc   = instr.fetch_pc;
		c    = p_q[cpu8x_pkg::FLAG_C];
		bin  = '0; lo = '0; hi = '0; slo = '0; shi = '0; r = '0; dres = '0;
		take = 1'b0; isbr = 1'b0; np = '0; pc1 = '0;
		ex.wv = 1'b0; ex.wa = instr.target_address; ex.wd = 8'h00; ex.pc = pc;
		ex.a = a_q; ex.x = x_q; ex.y = y_q; ex.p = p_q; ex.sp = sp_q; ex.cost = 3'd1;
		ex_push_n = 2'd0; ex_pull_n = 2'd0;
		ex_pb0 = 8'h00; ex_pb1 = 8'h00; ex_pb2 = 8'h00;
		unique case (op)
			cpu8x_pkg::OP_ADC: begin
				bin = 9'(a) + 9'(v) + 9'(c);
				if (p_q[cpu8x_pkg::FLAG_D]) begin
					lo = 5'(a[3:0]) + 5'(v[3:0]) + 5'(c);
					hi = 5'(a[7:4]) + 5'(v[7:4]);
					if (lo > 5'd9) begin
						lo = lo - 5'd10;
						hi = hi + 5'd1;
					end
					dres = {hi[3:0], lo[3:0]};
					ex.p[cpu8x_pkg::FLAG_Z] = (bin[7:0] == 8'h00);
					ex.p[cpu8x_pkg::FLAG_N] = dres[7];
					ex.p[cpu8x_pkg::FLAG_V] = ~(a[7] ^ v[7]) & (a[7] ^ dres[7]);
					if (hi > 5'd9) begin
						dres = dres - 8'hA0;
						ex.p[cpu8x_pkg::FLAG_C] = 1'b1;
					end else begin
						ex.p[cpu8x_pkg::FLAG_C] = 1'b0;
					end
					ex.a = dres;
				end else begin
					ex.a = bin[7:0];
					ex.p = set_zn(p_q, bin[7:0]);
					ex.p[cpu8x_pkg::FLAG_C] = bin[8];
					ex.p[cpu8x_pkg::FLAG_V] = ~(a[7] ^ v[7]) & (a[7] ^ bin[7]);
				end
			end
			cpu8x_pkg::OP_SBC: begin
				bin = 9'(a) + {1'b0, ~v} + 9'(c);
				if (p_q[cpu8x_pkg::FLAG_D]) begin
					slo = 6'(a[3:0]) - 6'(v[3:0]) - 6'(!c);
					shi = 6'(a[7:4]) - 6'(v[7:4]);
					if (slo[5]) begin
						slo = slo + 6'd10;
						shi = shi - 6'd1;
					end
					dres = {shi[3:0], slo[3:0]};
					ex.p[cpu8x_pkg::FLAG_Z] = (bin[7:0] == 8'h00);
					ex.p[cpu8x_pkg::FLAG_N] = dres[7];
					ex.p[cpu8x_pkg::FLAG_V] = (a[7] ^ v[7]) & (a[7] ^ dres[7]);
					if (shi[5]) begin
						dres = dres + 8'hA0;
						ex.p[cpu8x_pkg::FLAG_C] = 1'b0;
					end else begin
						ex.p[cpu8x_pkg::FLAG_C] = 1'b1;
					end
					ex.a = dres;
				end else begin
					ex.a = bin[7:0];
					ex.p = set_zn(p_q, bin[7:0]);
					ex.p[cpu8x_pkg::FLAG_C] = bin[8];
					ex.p[cpu8x_pkg::FLAG_V] = (a[7] ^ v[7]) & (a[7] ^ bin[7]);
				end
			end
			cpu8x_pkg::OP_AND: begin
				ex.a = a & v;
				ex.p = set_zn(p_q, a & v);
			end
			cpu8x_pkg::OP_EOR: begin
				ex.a = a ^ v;
				ex.p = set_zn(p_q, a ^ v);
			end
			cpu8x_pkg::OP_ORA: begin
				ex.a = a | v;
				ex.p = set_zn(p_q, a | v);
			end
			cpu8x_pkg::OP_ASL, cpu8x_pkg::OP_LSR, cpu8x_pkg::OP_ROL,
			cpu8x_pkg::OP_ROR: begin
				priority case (op)
					cpu8x_pkg::OP_ASL: r = {v[6:0], 1'b0};
					cpu8x_pkg::OP_LSR: r = {1'b0, v[7:1]};
					cpu8x_pkg::OP_ROL: r = {v[6:0], c};
					default:           r = {c, v[7:1]};
				endcase
				ex.p = set_zn(p_q, r);
				ex.p[cpu8x_pkg::FLAG_C] = (op == cpu8x_pkg::OP_ASL ||
					op == cpu8x_pkg::OP_ROL) ? v[7] : v[0];
				if (instr.accumulator_mode) begin
					ex.a = r;
				end else begin
					ex.wv = 1'b1;
					ex.wd = r;
					ex.cost = (op == cpu8x_pkg::OP_ASL || op == cpu8x_pkg::OP_LSR) ?
						3'd3 : 3'd2;
				end
			end
			cpu8x_pkg::OP_BCC, cpu8x_pkg::OP_BCS, cpu8x_pkg::OP_BEQ,
			cpu8x_pkg::OP_BMI, cpu8x_pkg::OP_BNE, cpu8x_pkg::OP_BPL,
			cpu8x_pkg::OP_BVC, cpu8x_pkg::OP_BVS: begin
				isbr = 1'b1;
				priority case (op)
					cpu8x_pkg::OP_BCC: take = !p_q[cpu8x_pkg::FLAG_C];
					cpu8x_pkg::OP_BCS: take = p_q[cpu8x_pkg::FLAG_C];
					cpu8x_pkg::OP_BEQ: take = p_q[cpu8x_pkg::FLAG_Z];
					cpu8x_pkg::OP_BNE: take = !p_q[cpu8x_pkg::FLAG_Z];
					cpu8x_pkg::OP_BMI: take = p_q[cpu8x_pkg::FLAG_N];
					cpu8x_pkg::OP_BPL: take = !p_q[cpu8x_pkg::FLAG_N];
					cpu8x_pkg::OP_BVS: take = p_q[cpu8x_pkg::FLAG_V];
					default:           take = !p_q[cpu8x_pkg::FLAG_V];
				endcase
				np = pc + instr.target_address;
				if (take) begin
					ex.pc = np;
					ex.cost = (np[15:8] != pc[15:8]) ? 3'd3 : 3'd2;
				end
			end
			cpu8x_pkg::OP_BIT: begin
				ex.p[cpu8x_pkg::FLAG_Z] = ((a & v) == 8'h00);
				ex.p[cpu8x_pkg::FLAG_V] = v[6];
				ex.p[cpu8x_pkg::FLAG_N] = v[7];
			end
			cpu8x_pkg::OP_BRK: begin
				pc1 = pc + 16'd1;
				ex_pb0 = pc1[15:8];
				ex_pb1 = pc1[7:0];
				ex_pb2 = p_q | cpu8x_pkg::PUSH_BU;
				ex_push_n = 2'd3;
				ex.sp = sp_q - 8'd3;
				ex.pc = bv_q;
				ex.p[cpu8x_pkg::FLAG_I] = 1'b1;
				ex.cost = 3'd6;
			end
			cpu8x_pkg::OP_JSR: begin
				pc1 = pc - 16'd1;
				ex_pb0 = pc1[15:8];
				ex_pb1 = pc1[7:0];
				ex_push_n = 2'd2;
				ex.sp = sp_q - 8'd2;
				ex.pc = instr.target_address;
				ex.cost = 3'd3;
			end
			cpu8x_pkg::OP_PHA: begin
				ex_pb0 = a_q;
				ex_push_n = 2'd1;
				ex.sp = sp_q - 8'd1;
				ex.cost = 3'd2;
			end
			cpu8x_pkg::OP_PHP: begin
				ex_pb0 = p_q | cpu8x_pkg::PUSH_BU;
				ex_push_n = 2'd1;
				ex.sp = sp_q - 8'd1;
				ex.cost = 3'd2;
			end
			cpu8x_pkg::OP_PLA, cpu8x_pkg::OP_PLP: ex_pull_n = 2'd1;
			cpu8x_pkg::OP_RTS: ex_pull_n = 2'd2;
			cpu8x_pkg::OP_RTI: ex_pull_n = 2'd3;
			cpu8x_pkg::OP_CLC: ex.p[cpu8x_pkg::FLAG_C] = 1'b0;
			cpu8x_pkg::OP_CLD: ex.p[cpu8x_pkg::FLAG_D] = 1'b0;
			cpu8x_pkg::OP_CLI: ex.p[cpu8x_pkg::FLAG_I] = 1'b0;
			cpu8x_pkg::OP_CLV: ex.p[cpu8x_pkg::FLAG_V] = 1'b0;
			cpu8x_pkg::OP_SEC: ex.p[cpu8x_pkg::FLAG_C] = 1'b1;
			cpu8x_pkg::OP_SED: ex.p[cpu8x_pkg::FLAG_D] = 1'b1;
			cpu8x_pkg::OP_SEI: ex.p[cpu8x_pkg::FLAG_I] = 1'b1;
			cpu8x_pkg::OP_CMP, cpu8x_pkg::OP_CPX, cpu8x_pkg::OP_CPY: begin
				priority case (op)
					cpu8x_pkg::OP_CMP: r = a_q;
					cpu8x_pkg::OP_CPX: r = x_q;
					default:           r = y_q;
				endcase
				ex.p = set_zn(p_q, r - v);
				ex.p[cpu8x_pkg::FLAG_C] = (r >= v);
			end
			cpu8x_pkg::OP_DEC, cpu8x_pkg::OP_INC: begin
				r = (op == cpu8x_pkg::OP_DEC) ? v - 8'd1 : v + 8'd1;
				ex.wv = 1'b1;
				ex.wd = r;
				ex.p = set_zn(p_q, r);
				ex.cost = 3'd3;
			end
			cpu8x_pkg::OP_DEX: begin
				ex.x = x_q - 8'd1;
				ex.p = set_zn(p_q, x_q - 8'd1);
			end
			cpu8x_pkg::OP_DEY: begin
				ex.y = y_q - 8'd1;
				ex.p = set_zn(p_q, y_q - 8'd1);
			end
			cpu8x_pkg::OP_INX: begin
				ex.x = x_q + 8'd1;
				ex.p = set_zn(p_q, x_q + 8'd1);
			end
			cpu8x_pkg::OP_INY: begin
				ex.y = y_q + 8'd1;
				ex.p = set_zn(p_q, y_q + 8'd1);
			end
			cpu8x_pkg::OP_JMP: ex.pc = instr.target_address;
			cpu8x_pkg::OP_LDA: begin
				ex.a = v;
				ex.p = set_zn(p_q, v);
			end
			cpu8x_pkg::OP_LDX: begin
				ex.x = v;
				ex.p = set_zn(p_q, v);
			end
			cpu8x_pkg::OP_LDY: begin
				ex.y = v;
				ex.p = set_zn(p_q, v);
			end
			cpu8x_pkg::OP_NOP: ex.cost = 3'd1;
			cpu8x_pkg::OP_STA: begin
				ex.wv = 1'b1;
				ex.wd = a_q;
			end
			cpu8x_pkg::OP_STX: begin
				ex.wv = 1'b1;
				ex.wd = x_q;
			end
			cpu8x_pkg::OP_STY: begin
				ex.wv = 1'b1;
				ex.wd = y_q;
			end
			cpu8x_pkg::OP_TAX: begin
				ex.x = a_q;
				ex.p = set_zn(p_q, a_q);
			end
			cpu8x_pkg::OP_TAY: begin
				ex.y = a_q;
				ex.p = set_zn(p_q, a_q);
			end
			cpu8x_pkg::OP_TSX: begin
				ex.x = sp_q;
				ex.p = set_zn(p_q, sp_q);
			end
			cpu8x_pkg::OP_TXA: begin
				ex.a = x_q;
				ex.p = set_zn(p_q, x_q);
			end
			cpu8x_pkg::OP_TXS: ex.sp = x_q;
			cpu8x_pkg::OP_TYA: begin
				ex.a = y_q;
				ex.p = set_zn(p_q, y_q);
			end
			default: ex.cost = 3'd0;
		endcase
		if (!ex.wv) begin
			ex.wa = 16'h0000;
		end
		// Branch decode flags also restore the fetch PC when a branch is not taken.
		if (isbr && !take) begin
			ex.pc = pc;
		end
	end

	// Result of a pull instruction once its last stack byte is back.
	always_comb begin
		logic [15:0] ret;
		pl.wv = 1'b0; pl.wa = 16'h0000; pl.wd = 8'h00; pl.pc = pop_pc_q;
		pl.a = a_q; pl.x = x_q; pl.y = y_q; pl.p = p_q;
		pl.sp = sp_q + 8'(pop_n_q);
		pl.cost = 3'd3;
		ret = 16'h0000;
		priority case (pop_op_q)
			cpu8x_pkg::OP_PLA: begin
				pl.a = ram_rd;
				pl.p = set_zn(p_q, ram_rd);
			end
			cpu8x_pkg::OP_PLP: begin
				pl.p = ram_rd;
				pl.p[cpu8x_pkg::FLAG_U] = 1'b1;
			end
			cpu8x_pkg::OP_RTS: begin
				ret = {ram_rd, byte0_q};
				pl.pc = ret + 16'd1;
				pl.cost = 3'd5;
			end
			default: begin
				pl.p = byte0_q;
				pl.p[cpu8x_pkg::FLAG_U] = 1'b1;
				pl.pc = {ram_rd, byte1_q};
				pl.cost = 3'd5;
			end
		endcase
	end

	// Stack RAM port steering.
	always_comb begin
		ram_we = 1'b0;
		ram_wa = wa_q;
		ram_wd = push_b0_q;
		ram_ra = ra_q;
		unique case (state_q)
			cpu8x_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				ram_wa = clr_q;
				ram_wd = 8'h00;
			end
			cpu8x_pkg::ST_PUSH: ram_we = 1'b1;
			cpu8x_pkg::ST_PULL: ram_ra = ra_q;
			cpu8x_pkg::ST_IDLE: begin
				ram_ra = sp_q + 8'd1;
				if (fire && ex_push_n != 2'd0) begin
					ram_we = 1'b1;
					ram_wa = sp_q;
					ram_wd = ex_pb0;
				end
			end
			default: ram_we = 1'b0;
		endcase
	end

	cpu8x_ram #(
		.WIDTH(8),
		.DEPTH(256)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_wa),
		.wdata(ram_wd),
		.raddr(ram_ra),
		.rdata(ram_rd)
	);

	// Next state of the sequencer.
	always_comb begin
		state_d  = state_q;
		load_res = 1'b0;
		unique case (state_q)
			cpu8x_pkg::ST_CLEAR: begin
				if (clr_q == 8'hFF) begin
					state_d = cpu8x_pkg::ST_IDLE;
				end
			end
			cpu8x_pkg::ST_IDLE: begin
				if (fire) begin
					if (ex_pull_n != 2'd0) begin
						state_d = cpu8x_pkg::ST_PULL;
					end else begin
						load_res = 1'b1;
						if (ex_push_n > 2'd1) begin
							state_d = cpu8x_pkg::ST_PUSH;
						end
					end
				end
			end
			cpu8x_pkg::ST_PUSH: begin
				if (push_n_q == 2'd1) begin
					state_d = cpu8x_pkg::ST_IDLE;
				end
			end
			cpu8x_pkg::ST_PULL: begin
				if (pull_done) begin
					load_res = 1'b1;
					state_d = cpu8x_pkg::ST_IDLE;
				end
			end
			default: state_d = cpu8x_pkg::ST_IDLE;
		endcase
	end

	// Architectural registers, sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cpu8x_pkg::ST_CLEAR;
			clr_q    <= 8'h00;
			a_q      <= 8'h00;
			x_q      <= 8'h00;
			y_q      <= 8'h00;
			sp_q     <= cpu8x_pkg::SP_RESET;
			p_q      <= cpu8x_pkg::P_RESET;
			bv_q     <= 16'h0000;
			push_n_q <= 2'd0;
			pop_n_q  <= 2'd0;
			pop_i_q  <= 2'd0;
			res_v_q  <= 1'b0;
			pop_op_q <= cpu8x_pkg::OP_ILL;
		end else begin
			state_q <= state_d;
			if (break_vector_we) begin
				bv_q <= break_vector_wdata;
			end
			if (state_q == cpu8x_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 8'd1;
			end
			if (fire && ex_pull_n == 2'd0) begin
				a_q  <= ex.a;
				x_q  <= ex.x;
				y_q  <= ex.y;
				sp_q <= ex.sp;
				p_q  <= ex.p;
			end
			if (fire) begin
				push_n_q <= ex_push_n - 2'd1;
				pop_n_q  <= ex_pull_n;
				pop_i_q  <= 2'd0;
				pop_op_q <= op;
			end
			if (state_q == cpu8x_pkg::ST_PUSH) begin
				push_n_q <= push_n_q - 2'd1;
			end
			if (state_q == cpu8x_pkg::ST_PULL) begin
				pop_i_q <= pop_i_q + 2'd1;
			end
			if (pull_done) begin
				a_q  <= pl.a;
				sp_q <= pl.sp;
				p_q  <= pl.p;
			end
			if (load_res) begin
				res_v_q <= 1'b1;
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (fire) begin
			wa_q      <= sp_q - 8'd1;
			push_b0_q <= ex_pb1;
			push_b1_q <= ex_pb2;
			ra_q      <= sp_q + 8'd2;
			pop_pc_q  <= instr.fetch_pc;
		end
		if (state_q == cpu8x_pkg::ST_PUSH) begin
			wa_q      <= wa_q - 8'd1;
			push_b0_q <= push_b1_q;
		end
		if (state_q == cpu8x_pkg::ST_PULL) begin
			ra_q <= ra_q + 8'd1;
			if (pop_i_q == 2'd0) begin
				byte0_q <= ram_rd;
			end
			if (pop_i_q == 2'd1) begin
				byte1_q <= ram_rd;
			end
		end
		if (load_res) begin
			res_q <= pull_done ? pl : ex;
		end
	end

	assign result.valid         = res_v_q;
	assign result.write_valid   = res_q.wv;
	assign result.write_address = res_q.wa;
	assign result.write_data    = res_q.wd;
	assign result.next_pc       = res_q.pc;
	assign result.acc_out       = res_q.a;
	assign result.x_out         = res_q.x;
	assign result.y_out         = res_q.y;
	assign result.status_out    = res_q.p;
	assign result.sp_out        = res_q.sp;
	assign result.cost          = res_q.cost;

	// Checks on the sequencer.
	`CPU8_ASSERT(a_busy_no_accept, clk, arst_n, state_q != cpu8x_pkg::ST_IDLE, !instr.ready)
	`CPU8_ASSERT(a_pull_no_write, clk, arst_n, state_q == cpu8x_pkg::ST_PULL, !ram_we)
	`CPU8_ASSERT(a_load_slot_free, clk, arst_n, load_res, slot_free)
	`CPU8_ASSERT_NEXT(a_pha_sp_dec, clk, arst_n, fire && op == cpu8x_pkg::OP_PHA, sp_q == $past(sp_q) - 8'd1)
endmodule
